>>> sv/pwmc_pkg.sv
// ----------------------------------------------------------------------------
// PWM setting calculator package
// Shared widths, status codes, register indexes and the control word that
// travels with each request through the back half of the pipeline.
// ----------------------------------------------------------------------------
package pwmc_pkg;

    localparam int NS_W        = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam int MIN_W       = 16;
    localparam int LIM_W       = 24;
    localparam int FREQ_W      = 24;
    localparam int RES_W       = 4;
    localparam int DUTY_W      = 10;
    localparam int STATUS_W    = 3;
    localparam int TIME_W      = 32;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [FREQ_W-1:0] FREQ_SAT = 24'hFFFFFF;

    // register reset values
    localparam logic [MIN_W-1:0] MIN_PULSE_RST = 16'd62;
    localparam logic [LIM_W-1:0] LIM_TEN_RST   = 24'd80000;
    localparam logic [LIM_W-1:0] LIM_EIGHT_RST = 24'd300000;
    localparam logic [LIM_W-1:0] LIM_SIX_RST   = 24'd1200000;
    localparam logic [LIM_W-1:0] LIM_FOUR_RST  = 24'd5000000;

    // resolution choices before capping
    localparam logic [RES_W-1:0] RES_TEN   = 4'd10;
    localparam logic [RES_W-1:0] RES_EIGHT = 4'd8;
    localparam logic [RES_W-1:0] RES_SIX   = 4'd6;
    localparam logic [RES_W-1:0] RES_FOUR  = 4'd4;
    localparam logic [RES_W-1:0] RES_ONE   = 4'd1;
    localparam logic [RES_W-1:0] RES_NONE  = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PULSE = 3'd0,
        CFG_LIM_TEN   = 3'd1,
        CFG_LIM_EIGHT = 3'd2,
        CFG_LIM_SIX   = 3'd3,
        CFG_LIM_FOUR  = 3'd4
    } pwmc_cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN       = 3'd0,
        ST_OFF       = 3'd1,
        ST_TOO_SMALL = 3'd2,
        ST_RATIO     = 3'd3,
        ST_FREQ_HIGH = 3'd4,
        ST_DUTY_ZERO = 3'd5
    } pwmc_status_t;

    typedef struct packed {
        pwmc_status_t      status;
        logic [RES_W-1:0]  res;
        logic [FREQ_W-1:0] freq;
    } pwmc_ctl_t;

endpackage

>>> sv/pwmc_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// One radix-2 restoring step for three divisions at once: on time and off
// time modulo the minimum pulse width, and one billion over the period.
// ----------------------------------------------------------------------------
module pwmc_div_cell
    import pwmc_pkg::*;
#(
    parameter int W       = 32,
    parameter int BIT_POS = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic [MIN_W-1:0] min_pulse,
    input  logic [W-1:0]     on_in,
    input  logic [W-1:0]     off_in,
    input  logic [W:0]       period_in,
    input  logic [MIN_W-1:0] rem_on_in,
    input  logic [MIN_W-1:0] rem_off_in,
    input  logic [W:0]       rem_f_in,
    input  logic [NS_W-1:0]  quot_in,
    output logic [W-1:0]     on_out,
    output logic [W-1:0]     off_out,
    output logic [W:0]       period_out,
    output logic [MIN_W-1:0] rem_on_out,
    output logic [MIN_W-1:0] rem_off_out,
    output logic [W:0]       rem_f_out,
    output logic [NS_W-1:0]  quot_out
);

    logic             valid_reg;
    logic [W-1:0]     on_reg;
    logic [W-1:0]     off_reg;
    logic [W:0]       period_reg;
    logic [MIN_W-1:0] rem_on_reg;
    logic [MIN_W-1:0] rem_off_reg;
    logic [W:0]       rem_f_reg;
    logic [NS_W-1:0]  quot_reg;

    logic             on_bit;
    logic             off_bit;
    logic             ns_bit;
    logic [MIN_W:0]   sh_on;
    logic [MIN_W:0]   sh_off;
    logic [MIN_W:0]   diff_on;
    logic [MIN_W:0]   diff_off;
    logic [W+1:0]     sh_f;
    logic [W+1:0]     diff_f;
    logic             ge_on;
    logic             ge_off;
    logic             ge_f;
    logic [MIN_W-1:0] rem_on_next;
    logic [MIN_W-1:0] rem_off_next;
    logic [W:0]       rem_f_next;
    logic [NS_W-1:0]  quot_next;

    // pick the dividend bits this cell consumes
    if (BIT_POS < W) begin : g_time_bit
        assign on_bit  = on_in[BIT_POS];
        assign off_bit = off_in[BIT_POS];
    end
    else begin : g_time_zero
        assign on_bit  = 1'b0;
        assign off_bit = 1'b0;
    end

    if (BIT_POS < NS_W) begin : g_ns_bit
        assign ns_bit = NS_PER_SEC[BIT_POS];
    end
    else begin : g_ns_zero
        assign ns_bit = 1'b0;
    end

    // shift in one bit, subtract the divisor when it fits
    always_comb
    begin
        sh_on        = {rem_on_in, on_bit};
        sh_off       = {rem_off_in, off_bit};
        diff_on      = sh_on - {1'b0, min_pulse};
        diff_off     = sh_off - {1'b0, min_pulse};
        ge_on        = (sh_on >= {1'b0, min_pulse});
        ge_off       = (sh_off >= {1'b0, min_pulse});
        rem_on_next  = ge_on ? diff_on[MIN_W-1:0] : sh_on[MIN_W-1:0];
        rem_off_next = ge_off ? diff_off[MIN_W-1:0] : sh_off[MIN_W-1:0];

        sh_f         = {rem_f_in, ns_bit};
        diff_f       = sh_f - {1'b0, period_in};
        ge_f         = (sh_f >= {1'b0, period_in});
        rem_f_next   = ge_f ? diff_f[W:0] : sh_f[W:0];
        quot_next    = {quot_in[NS_W-2:0], ge_f};
    end

    assign in_ready = !valid_reg || out_ready;

    // hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            on_reg      <= on_in;
            off_reg     <= off_in;
            period_reg  <= period_in;
            rem_on_reg  <= rem_on_next;
            rem_off_reg <= rem_off_next;
            rem_f_reg   <= rem_f_next;
            quot_reg    <= quot_next;
        end
    end

    assign out_valid   = valid_reg;
    assign on_out      = on_reg;
    assign off_out     = off_reg;
    assign period_out  = period_reg;
    assign rem_on_out  = rem_on_reg;
    assign rem_off_out = rem_off_reg;
    assign rem_f_out   = rem_f_reg;
    assign quot_out    = quot_reg;

endmodule

>>> sv/pwmc_select.sv
// ----------------------------------------------------------------------------
// Check and resolution select stage
// Applies the width and ratio checks, picks the bit resolution from the
// frequency limits and saturates the reported frequency.
// ----------------------------------------------------------------------------
module pwmc_select
    import pwmc_pkg::*;
#(
    parameter int W    = 32,
    parameter int MAXR = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic [MIN_W-1:0] min_pulse,
    input  logic [LIM_W-1:0] lim_ten,
    input  logic [LIM_W-1:0] lim_eight,
    input  logic [LIM_W-1:0] lim_six,
    input  logic [LIM_W-1:0] lim_four,
    input  logic [W-1:0]     on_in,
    input  logic [W-1:0]     off_in,
    input  logic [W:0]       period_in,
    input  logic [MIN_W-1:0] rem_on_in,
    input  logic [MIN_W-1:0] rem_off_in,
    input  logic [NS_W-1:0]  freq_in,
    output logic [W-1:0]     on_out,
    output logic [W:0]       period_out,
    output pwmc_ctl_t        ctl_out
);

    localparam int CW = (W > 20) ? W : 20;

    logic          valid_reg;
    logic [W-1:0]  on_reg;
    logic [W:0]    period_reg;
    pwmc_ctl_t     ctl_reg;
    pwmc_ctl_t     ctl_next;

    logic             is_zero;
    logic             is_small;
    logic             ratio_on;
    logic             ratio_off;
    logic [19:0]      r10_on;
    logic [19:0]      r10_off;
    logic [RES_W-1:0] res_raw;
    logic [RES_W-1:0] res_cap;

    // remainder times ten against the width itself
    always_comb
    begin
        r10_on    = 20'({rem_on_in, 3'b000}) + 20'({rem_on_in, 1'b0});
        r10_off   = 20'({rem_off_in, 3'b000}) + 20'({rem_off_in, 1'b0});
        ratio_on  = (min_pulse != '0) && (CW'(r10_on) > CW'(on_in));
        ratio_off = (min_pulse != '0) && (CW'(r10_off) > CW'(off_in));
        is_zero   = (on_in == '0) || (off_in == '0);
        is_small  = (on_in < W'(min_pulse)) || (off_in < W'(min_pulse));
    end

    // pick resolution from the first matching limit
    always_comb
    begin
        if (freq_in <= NS_W'(lim_ten))
        begin
            res_raw = RES_TEN;
        end
        else if (freq_in <= NS_W'(lim_eight))
        begin
            res_raw = RES_EIGHT;
        end
        else if (freq_in < NS_W'(lim_six))
        begin
            res_raw = RES_SIX;
        end
        else if (freq_in < NS_W'(lim_four))
        begin
            res_raw = RES_FOUR;
        end
        else if (on_in == off_in)
        begin
            res_raw = RES_ONE;
        end
        else
        begin
            res_raw = RES_NONE;
        end
        res_cap = (int'(res_raw) > MAXR) ? RES_W'(MAXR) : res_raw;
    end

    // build the control word
    always_comb
    begin
        ctl_next.res  = res_cap;
        ctl_next.freq = (freq_in > NS_W'(FREQ_SAT)) ? FREQ_SAT : freq_in[FREQ_W-1:0];
        if (is_zero)
        begin
            ctl_next.status = ST_OFF;
        end
        else if (is_small)
        begin
            ctl_next.status = ST_TOO_SMALL;
        end
        else if (ratio_on || ratio_off)
        begin
            ctl_next.status = ST_RATIO;
        end
        else if (res_cap == RES_NONE)
        begin
            ctl_next.status = ST_FREQ_HIGH;
        end
        else
        begin
            ctl_next.status = ST_RUN;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            on_reg     <= on_in;
            period_reg <= period_in;
            ctl_reg    <= ctl_next;
        end
    end

    assign out_valid  = valid_reg;
    assign on_out     = on_reg;
    assign period_out = period_reg;
    assign ctl_out    = ctl_reg;

endmodule

>>> sv/pwmc_duty_cell.sv
// ----------------------------------------------------------------------------
// Duty division cell
// One radix-2 restoring step of on time over period, producing one duty
// quotient bit per cell.
// ----------------------------------------------------------------------------
module pwmc_duty_cell
    import pwmc_pkg::*;
#(
    parameter int W    = 32,
    parameter int MAXR = 10
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  logic [W:0]      period_in,
    input  logic [W:0]      rem_in,
    input  logic [MAXR-1:0] quot_in,
    input  pwmc_ctl_t       ctl_in,
    output logic [W:0]      period_out,
    output logic [W:0]      rem_out,
    output logic [MAXR-1:0] quot_out,
    output pwmc_ctl_t       ctl_out
);

    logic            valid_reg;
    logic [W:0]      period_reg;
    logic [W:0]      rem_reg;
    logic [MAXR-1:0] quot_reg;
    pwmc_ctl_t       ctl_reg;

    logic [W+1:0]    sh;
    logic [W+1:0]    diff;
    logic            ge;
    logic [W:0]      rem_next;
    logic [MAXR-1:0] quot_next;

    // double the remainder, subtract the period when it fits
    always_comb
    begin
        sh        = {rem_in, 1'b0};
        diff      = sh - {1'b0, period_in};
        ge        = (sh >= {1'b0, period_in});
        rem_next  = ge ? diff[W:0] : sh[W:0];
        quot_next = {quot_in[MAXR-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            period_reg <= period_in;
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
            ctl_reg    <= ctl_in;
        end
    end

    assign out_valid  = valid_reg;
    assign period_out = period_reg;
    assign rem_out    = rem_reg;
    assign quot_out   = quot_reg;
    assign ctl_out    = ctl_reg;

endmodule

>>> sv/pwm_setting_calculator.sv
// ----------------------------------------------------------------------------
// PWM setting calculator
// Turns an on and off time request into status, frequency, resolution and
// duty count through a chain of one-bit division cells.
// ----------------------------------------------------------------------------
// A new word can be taken every cycle unless a stalled output has filled the
// chain. Each result passes through a row of radix-2 division cells: one
// cell per bit of the frequency and remainder divisions, one select stage, one
// cell per duty bit, and the output register. Every cell holds its word
// independently, so a stalled output only backs up as far as the first empty
// cell. Limits and minimum pulse width are read live by every request and
// should be written only while no request is in flight.
module pwm_setting_calculator
    import pwmc_pkg::*;
#(
    parameter int WIDTH_BITS     = 32,
    parameter int MAX_RESOLUTION = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] on_time_ns, [63:32] off_time_ns
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] status, [26:3] frequency_hz, [30:27] resolution_bits,
    // [40:31] duty_count, [47:41] zero
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int W    = WIDTH_BITS;
    localparam int MAXR = MAX_RESOLUTION;
    localparam int N    = (W > NS_W) ? W : NS_W;
    localparam int SH_W = $clog2(MAXR + 1);
    localparam int DW   = (MAXR > DUTY_W) ? MAXR : DUTY_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MIN_W-1:0] min_pulse_reg;
    logic [LIM_W-1:0] lim_ten_reg;
    logic [LIM_W-1:0] lim_eight_reg;
    logic [LIM_W-1:0] lim_six_reg;
    logic [LIM_W-1:0] lim_four_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            lim_ten_reg   <= LIM_TEN_RST;
            lim_eight_reg <= LIM_EIGHT_RST;
            lim_six_reg   <= LIM_SIX_RST;
            lim_four_reg  <= LIM_FOUR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_data[MIN_W-1:0];
                CFG_LIM_TEN:   lim_ten_reg   <= cfg_data[LIM_W-1:0];
                CFG_LIM_EIGHT: lim_eight_reg <= cfg_data[LIM_W-1:0];
                CFG_LIM_SIX:   lim_six_reg   <= cfg_data[LIM_W-1:0];
                CFG_LIM_FOUR:  lim_four_reg  <= cfg_data[LIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // division chain: remainders and frequency
    // ------------------------------------------------------------------
    logic             dv_valid  [N+1];
    logic             dv_ready  [N+1];
    logic [W-1:0]     dv_on     [N+1];
    logic [W-1:0]     dv_off    [N+1];
    logic [W:0]       dv_period [N+1];
    logic [MIN_W-1:0] dv_rem_on [N+1];
    logic [MIN_W-1:0] dv_rem_off[N+1];
    logic [W:0]       dv_rem_f  [N+1];
    logic [NS_W-1:0]  dv_quot   [N+1];

    // unpack the word and seed the chain
    assign dv_valid[0]   = s_tvalid;
    assign s_tready      = dv_ready[0];
    assign dv_on[0]      = W'(s_tdata[TIME_W-1:0]);
    assign dv_off[0]     = W'(s_tdata[2*TIME_W-1:TIME_W]);
    assign dv_period[0]  = {1'b0, dv_on[0]} + {1'b0, dv_off[0]};
    assign dv_rem_on[0]  = '0;
    assign dv_rem_off[0] = '0;
    assign dv_rem_f[0]   = '0;
    assign dv_quot[0]    = '0;

    for (genvar k = 0; k < N; k++) begin : g_div
        pwmc_div_cell #(
            .W       (W),
            .BIT_POS (N - 1 - k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (dv_valid[k]),
            .in_ready    (dv_ready[k]),
            .out_valid   (dv_valid[k+1]),
            .out_ready   (dv_ready[k+1]),
            .min_pulse   (min_pulse_reg),
            .on_in       (dv_on[k]),
            .off_in      (dv_off[k]),
            .period_in   (dv_period[k]),
            .rem_on_in   (dv_rem_on[k]),
            .rem_off_in  (dv_rem_off[k]),
            .rem_f_in    (dv_rem_f[k]),
            .quot_in     (dv_quot[k]),
            .on_out      (dv_on[k+1]),
            .off_out     (dv_off[k+1]),
            .period_out  (dv_period[k+1]),
            .rem_on_out  (dv_rem_on[k+1]),
            .rem_off_out (dv_rem_off[k+1]),
            .rem_f_out   (dv_rem_f[k+1]),
            .quot_out    (dv_quot[k+1])
        );
    end

    // ------------------------------------------------------------------
    // checks and resolution
    // ------------------------------------------------------------------
    logic            dt_valid  [MAXR+1];
    logic            dt_ready  [MAXR+1];
    logic [W:0]      dt_period [MAXR+1];
    logic [W:0]      dt_rem    [MAXR+1];
    logic [MAXR-1:0] dt_quot   [MAXR+1];
    pwmc_ctl_t       dt_ctl    [MAXR+1];
    logic [W-1:0]    sel_on;

    pwmc_select #(
        .W    (W),
        .MAXR (MAXR)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv_valid[N]),
        .in_ready   (dv_ready[N]),
        .out_valid  (dt_valid[0]),
        .out_ready  (dt_ready[0]),
        .min_pulse  (min_pulse_reg),
        .lim_ten    (lim_ten_reg),
        .lim_eight  (lim_eight_reg),
        .lim_six    (lim_six_reg),
        .lim_four   (lim_four_reg),
        .on_in      (dv_on[N]),
        .off_in     (dv_off[N]),
        .period_in  (dv_period[N]),
        .rem_on_in  (dv_rem_on[N]),
        .rem_off_in (dv_rem_off[N]),
        .freq_in    (dv_quot[N]),
        .on_out     (sel_on),
        .period_out (dt_period[0]),
        .ctl_out    (dt_ctl[0])
    );

    // on time is below the period, so it seeds the remainder directly
    assign dt_rem[0]  = {1'b0, sel_on};
    assign dt_quot[0] = '0;

    // ------------------------------------------------------------------
    // duty chain
    // ------------------------------------------------------------------
    for (genvar k = 0; k < MAXR; k++) begin : g_duty
        pwmc_duty_cell #(
            .W    (W),
            .MAXR (MAXR)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (dt_valid[k]),
            .in_ready   (dt_ready[k]),
            .out_valid  (dt_valid[k+1]),
            .out_ready  (dt_ready[k+1]),
            .period_in  (dt_period[k]),
            .rem_in     (dt_rem[k]),
            .quot_in    (dt_quot[k]),
            .ctl_in     (dt_ctl[k]),
            .period_out (dt_period[k+1]),
            .rem_out    (dt_rem[k+1]),
            .quot_out   (dt_quot[k+1]),
            .ctl_out    (dt_ctl[k+1])
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    pwmc_status_t        status_reg;
    pwmc_status_t        status_next;
    logic [FREQ_W-1:0]   freq_reg;
    logic [FREQ_W-1:0]   freq_next;
    logic [RES_W-1:0]    res_reg;
    logic [RES_W-1:0]    res_next;
    logic [DUTY_W-1:0]   duty_reg;
    logic [DUTY_W-1:0]   duty_next;
    logic [SH_W-1:0]     shamt;
    logic [MAXR-1:0]     duty_full;
    logic [DW-1:0]       duty_ext;
    logic                out_load;
    pwmc_ctl_t           fin_ctl;

    assign fin_ctl     = dt_ctl[MAXR];
    assign dt_ready[MAXR] = !m_valid_reg || m_tready;
    assign out_load    = dt_ready[MAXR] && dt_valid[MAXR];

    // drop the low quotient bits beyond the chosen resolution
    always_comb
    begin
        shamt     = SH_W'(MAXR) - SH_W'(fin_ctl.res);
        duty_full = dt_quot[MAXR] >> shamt;
        duty_ext  = DW'(duty_full);

        status_next = fin_ctl.status;
        if ((fin_ctl.status == ST_RUN) && (duty_full == '0))
        begin
            status_next = ST_DUTY_ZERO;
        end

        if (status_next == ST_RUN)
        begin
            freq_next = fin_ctl.freq;
            res_next  = fin_ctl.res;
            duty_next = duty_ext[DUTY_W-1:0];
        end
        else
        begin
            freq_next = '0;
            res_next  = '0;
            duty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (dt_ready[MAXR])
        begin
            m_valid_reg <= dt_valid[MAXR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            freq_reg   <= freq_next;
            res_reg    <= res_next;
            duty_reg   <= duty_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, duty_reg, res_reg, freq_reg, status_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input refused while output side can move");

    a_run_has_resolution: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (status_reg == ST_RUN)) |->
            ((res_reg != '0) && (int'(res_reg) <= MAXR)))
        else $error("running result without a legal resolution");

    a_fault_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (status_reg != ST_RUN)) |->
            ((freq_reg == '0) && (res_reg == '0) && (duty_reg == '0)))
        else $error("fault result carries nonzero fields");

    a_duty_zero_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (fin_ctl.status == ST_RUN) |=> (status_reg == ST_RUN) ||
            (status_reg == ST_DUTY_ZERO))
        else $error("running request turned into an unrelated fault");

endmodule

>>> test/pwm_setting_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting checker
// Watches the request and result streams, computes the expected status,
// frequency, resolution and duty count per accepted request, and compares.
// ----------------------------------------------------------------------------
module pwm_setting_checker
    import pwmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    logic [MIN_W-1:0] min_pulse;
    logic [LIM_W-1:0] lim_ten, lim_eight, lim_six, lim_four;
    logic [TDATA_OUT_W-1:0] settings_q[$];

    assign pending = settings_q.size();

    function automatic logic [TDATA_OUT_W-1:0] calc_setting(logic [TIME_W-1:0] on_ns,
                                                            logic [TIME_W-1:0] off_ns);
        pwmc_status_t st;
        logic [63:0]  period, freq, duty;
        logic [RES_W-1:0] bits;
        logic on_bad, off_bad;
        st = ST_RUN;
        freq = 0;
        bits = RES_NONE;
        duty = 0;
        on_bad = (min_pulse != 0) && ((on_ns % min_pulse) * 64'd10 > on_ns);
        off_bad = (min_pulse != 0) && ((off_ns % min_pulse) * 64'd10 > off_ns);
        if (on_ns == 0 || off_ns == 0)
            st = ST_OFF;
        else if (on_ns < min_pulse || off_ns < min_pulse)
            st = ST_TOO_SMALL;
        else if (on_bad || off_bad)
            st = ST_RATIO;
        else
        begin
            period = 64'(on_ns) + 64'(off_ns);
            freq = 64'd1000000000 / period;
            if (freq <= lim_ten)        bits = RES_TEN;
            else if (freq <= lim_eight) bits = RES_EIGHT;
            else if (freq < lim_six)    bits = RES_SIX;
            else if (freq < lim_four)   bits = RES_FOUR;
            else if (on_ns == off_ns)   bits = RES_ONE;
            if (bits == RES_NONE)
                st = ST_FREQ_HIGH;
            else
            begin
                duty = (64'(on_ns) << bits) / period;
                if (duty == 0)
                    st = ST_DUTY_ZERO;
            end
            if (freq > FREQ_SAT)
                freq = FREQ_SAT;
        end
        if (st != ST_RUN)
        begin
            freq = 0;
            bits = RES_NONE;
            duty = 0;
        end
        return {7'd0, duty[DUTY_W-1:0], bits, freq[FREQ_W-1:0], st};
    endfunction

    // track registers, queue expectations, compare results
    always @(posedge clk or negedge rst_n)
    begin
        logic [TDATA_OUT_W-1:0] want;
        if (!rst_n)
        begin
            min_pulse <= MIN_PULSE_RST;
            lim_ten   <= LIM_TEN_RST;
            lim_eight <= LIM_EIGHT_RST;
            lim_six   <= LIM_SIX_RST;
            lim_four  <= LIM_FOUR_RST;
            settings_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_PULSE: min_pulse <= cfg_data[MIN_W-1:0];
                    CFG_LIM_TEN:   lim_ten   <= cfg_data;
                    CFG_LIM_EIGHT: lim_eight <= cfg_data;
                    CFG_LIM_SIX:   lim_six   <= cfg_data;
                    CFG_LIM_FOUR:  lim_four  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                settings_q.push_back(calc_setting(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                if (settings_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = settings_q.pop_front();
                    if (want !== m_tdata)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: status %0d/%0d freq %0d/%0d res %0d/%0d duty %0d/%0d",
                                     want[2:0], m_tdata[2:0], want[26:3], m_tdata[26:3],
                                     want[30:27], m_tdata[30:27], want[40:31], m_tdata[40:31]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/pwm_setting_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting calculator testbench
// Drives directed and random on/off time requests under several register
// settings with random stalls on both streams; a checker scores the results.
// ----------------------------------------------------------------------------
module pwm_setting_calculator_tb;
    import pwmc_pkg::*;

    localparam int LATENCY = 44;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int fail_count;
    int pending;
    bit steady = 1'b0;
    int unsigned rand_min;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pwm_setting_calculator u_dut (.*);

    pwm_setting_checker u_chk (.*);

    // random backpressure on the result side
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 21);

    // hold the word until accepted; valid stays high for a back-to-back word
    task automatic send_times(logic [31:0] on_ns, logic [31:0] off_ns);
        while (!steady && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {off_ns, on_ns};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(pwmc_cfg_idx_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // times near a multiple of the minimum width so most pass the ratio check
    function automatic logic [31:0] legal_time(int unsigned step);
        logic [31:0] t;
        int unsigned k;
        k = ($urandom_range(3) == 0) ? $urandom_range(1000000) : $urandom_range(64);
        if (step == 0)
            return $urandom;
        t = 32'(k + 1) * step + $urandom_range(step / 11);
        return t;
    endfunction

    task automatic random_phase(int n, int unsigned step);
        repeat (n)
        begin
            if ($urandom_range(9) < 7)
                send_times(legal_time(step), legal_time(step));
            else if ($urandom_range(1) == 0)
                send_times($urandom, $urandom);
            else
                send_times($urandom_range(200), $urandom_range(200));
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero widths, narrow, ratio, resolutions, saturated period
        send_times(0, 0);
        send_times(100, 0);
        send_times(0, 100);
        send_times(61, 62);
        send_times(62, 61);
        send_times(69, 62);
        send_times(62, 69);
        send_times(62, 62);
        send_times(62, 124);
        send_times(6200, 6200);
        send_times(620, 620);
        send_times(124, 1240);
        send_times(62000, 62000);
        send_times(62, 620000);
        send_times(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_times(32'hFFFFFFC2, 32'hFFFFFFC2);
        send_times(186, 186);
        send_times(248, 62);
        drain();

        // zero minimum width, tight limits, then extremes
        write_reg(CFG_MIN_PULSE, 24'd0);
        write_reg(CFG_LIM_TEN, 24'd0);
        write_reg(CFG_LIM_EIGHT, 24'd1000);
        write_reg(CFG_LIM_SIX, 24'd50000);
        write_reg(CFG_LIM_FOUR, 24'hFFFFFF);
        send_times(1, 1);
        send_times(1, 2);
        send_times(3, 500000000);
        send_times(32'hFFFFFFFF, 1);
        random_phase(90, 0);
        drain();

        write_reg(CFG_MIN_PULSE, 24'd1);
        write_reg(CFG_LIM_TEN, 24'hFFFFFF);
        steady = 1'b1;
        random_phase(60, 1);
        steady = 1'b0;
        drain();

        write_reg(CFG_MIN_PULSE, 24'd65535);
        write_reg(CFG_LIM_TEN, 24'd0);
        write_reg(CFG_LIM_EIGHT, 24'd0);
        write_reg(CFG_LIM_SIX, 24'd0);
        write_reg(CFG_LIM_FOUR, 24'd0);
        random_phase(60, 65535);
        drain();

        write_reg(CFG_MIN_PULSE, 24'd62);
        write_reg(CFG_LIM_TEN, 24'd80000);
        write_reg(CFG_LIM_EIGHT, 24'd300000);
        write_reg(CFG_LIM_SIX, 24'd1200000);
        write_reg(CFG_LIM_FOUR, 24'd5000000);
        random_phase(100, 62);
        drain();

        // step for the last phase follows the written minimum width
        rand_min = $urandom_range(1, 500);
        write_reg(CFG_MIN_PULSE, 24'(rand_min));
        write_reg(CFG_LIM_TEN, 24'($urandom_range(100000)));
        write_reg(CFG_LIM_EIGHT, 24'($urandom_range(1000000)));
        write_reg(CFG_LIM_SIX, 24'($urandom_range(4000000)));
        write_reg(CFG_LIM_FOUR, 24'($urandom));
        random_phase(90, rand_min);
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
